// ===== design/nar_pkg.sv =====
// ----------------------------------------------------------------------------
// nar_pkg
// Shared types and codes for the no-adjacent-repeat reorderer.
// ----------------------------------------------------------------------------
package nar_pkg;

  // Field widths of the stream words
  localparam int LETTER_W = 5;
  localparam int DATA_W   = 8;
  localparam int USER_W   = 2;

  // Input word kinds carried on s_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // Result flag positions in m_tuser
  localparam int USER_IMPOSSIBLE = 0;
  localparam int USER_EMPTY      = 1;

  // Broadcast command to the counter cells
  typedef struct packed {
    logic clr;    // zero every count
    logic inc;    // add one at inc_idx
    logic dec_a;  // subtract one at dec_a_idx
    logic dec_b;  // subtract one at dec_b_idx
  } cell_cmd_t;

endpackage

// ===== design/no_adjacent_repeat_reorderer.sv =====
// ----------------------------------------------------------------------------
// no_adjacent_repeat_reorderer
// Letter histogram with greedy pairwise readout so no letter repeats.
// ----------------------------------------------------------------------------
// Load words can follow back to back while the block is idle.
// A pull that starts a new pair sends a top-two record down the chain of
// ALPHABET_SIZE counter cells, one register per cell, and then emits.
// A pull that returns the held second letter, or finds the store empty,
// goes straight to the emit state. A finished word waits in the output register.
// Reset (rst, synchronous) clears counts, total, readout flags and m_tvalid.
module no_adjacent_repeat_reorderer #(
  parameter int MAX_LEN       = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [nar_pkg::DATA_W-1:0]      s_tdata,   // [4:0] letter
  input  logic                            s_tuser,   // opcode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [nar_pkg::DATA_W-1:0]      m_tdata,   // [4:0] out_letter
  output logic                            m_tlast,   // last
  output logic [nar_pkg::USER_W-1:0]      m_tuser    // [0] impossible, [1] empty_res
);
  import nar_pkg::*;

  localparam int IW = $clog2(ALPHABET_SIZE);
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state, state_next;
  logic [CW-1:0]       total, total_next;
  logic [IW-1:0]       held_letter, held_letter_next;
  logic                held_valid, held_valid_next;
  logic                feas, feas_next;
  logic [LETTER_W-1:0] res_letter, res_letter_next;
  logic                res_last, res_last_next;
  logic                res_imp, res_imp_next;
  logic                res_empty, res_empty_next;
  logic [LETTER_W-1:0] out_letter;

  cell_cmd_t     cmd;
  logic [IW-1:0] inc_idx, dec_a_idx, dec_b_idx;

  logic [LETTER_W-1:0] s_letter;
  logic                s_fire;
  logic                letter_ok;
  logic [CW:0]         total_p1;
  logic [CW-1:0]       half_up;
  logic                scan_start;

  // Record chain: index 0 is the injection point, the last is the result
  logic          ch_vld [0:ALPHABET_SIZE];
  logic [CW-1:0] ch_c1  [0:ALPHABET_SIZE];
  logic [IW-1:0] ch_i1  [0:ALPHABET_SIZE];
  logic [CW-1:0] ch_c2  [0:ALPHABET_SIZE];
  logic [IW-1:0] ch_i2  [0:ALPHABET_SIZE];

  assign s_letter  = s_tdata[LETTER_W-1:0];
  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign letter_ok = 32'(s_letter) < 32'(ALPHABET_SIZE);
  assign total_p1  = {1'b0, total} + (CW+1)'(1);
  assign half_up   = total_p1[CW:1];

  assign ch_vld[0] = scan_start;
  assign ch_c1[0]  = '0;
  assign ch_i1[0]  = '0;
  assign ch_c2[0]  = '0;
  assign ch_i2[0]  = '0;

  // Counter cells
  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
    nar_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .inc_idx   (inc_idx),
      .dec_a_idx (dec_a_idx),
      .dec_b_idx (dec_b_idx),
      .in_vld    (ch_vld[g]),
      .in_c1     (ch_c1[g]),
      .in_i1     (ch_i1[g]),
      .in_c2     (ch_c2[g]),
      .in_i2     (ch_i2[g]),
      .out_vld   (ch_vld[g+1]),
      .out_c1    (ch_c1[g+1]),
      .out_i1    (ch_i1[g+1]),
      .out_c2    (ch_c2[g+1]),
      .out_i2    (ch_i2[g+1])
    );
  end

  // Control: word decode, pair selection and bookkeeping
  always_comb begin
    state_next       = state;
    total_next       = total;
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    feas_next        = feas;
    res_letter_next  = res_letter;
    res_last_next    = res_last;
    res_imp_next     = res_imp;
    res_empty_next   = res_empty;
    cmd              = '0;
    inc_idx          = IW'(s_letter);
    dec_a_idx        = ch_i1[ALPHABET_SIZE];
    dec_b_idx        = ch_i2[ALPHABET_SIZE];
    scan_start       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_fire && s_tuser == OP_LOAD) begin
          if (!feas && letter_ok && total < CW'(MAX_LEN)) begin
            cmd.inc    = 1'b1;
            total_next = total + CW'(1);
          end
        end else if (s_fire) begin
          res_letter_next = '0;
          res_last_next   = 1'b0;
          res_imp_next    = 1'b0;
          res_empty_next  = 1'b0;
          if (total == '0) begin
            res_empty_next = 1'b1;
            state_next     = ST_EMIT;
          end else if (held_valid) begin
            // second letter of the current pair
            res_letter_next  = LETTER_W'(held_letter);
            held_valid_next  = 1'b0;
            held_letter_next = '0;
            total_next       = total - CW'(1);
            if (total == CW'(1)) begin
              res_last_next = 1'b1;
              feas_next     = 1'b0;
            end
            state_next = ST_EMIT;
          end else begin
            scan_start = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ch_vld[ALPHABET_SIZE]) begin
          state_next = ST_EMIT;
          if (!feas && ch_c1[ALPHABET_SIZE] > half_up) begin
            // one letter dominates: give up and drop the store
            cmd.clr          = 1'b1;
            total_next       = '0;
            held_letter_next = '0;
            held_valid_next  = 1'b0;
            feas_next        = 1'b0;
            res_imp_next     = 1'b1;
            res_last_next    = 1'b1;
          end else if (ch_c1[ALPHABET_SIZE] == '0) begin
            // counts out of step with the total
            cmd.clr          = 1'b1;
            total_next       = '0;
            held_letter_next = '0;
            held_valid_next  = 1'b0;
            feas_next        = 1'b0;
            res_empty_next   = 1'b1;
          end else begin
            feas_next       = 1'b1;
            cmd.dec_a       = 1'b1;
            res_letter_next = LETTER_W'(ch_i1[ALPHABET_SIZE]);
            total_next      = total - CW'(1);
            if (ch_c2[ALPHABET_SIZE] != '0) begin
              cmd.dec_b        = 1'b1;
              held_letter_next = ch_i2[ALPHABET_SIZE];
              held_valid_next  = 1'b1;
            end else if (total == CW'(1)) begin
              res_last_next = 1'b1;
              feas_next     = 1'b0;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      total       <= '0;
      held_letter <= '0;
      held_valid  <= 1'b0;
      feas        <= 1'b0;
    end else begin
      state       <= state_next;
      total       <= total_next;
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
      feas        <= feas_next;
    end
  end

  // Pending result word
  always_ff @(posedge clk) begin
    res_letter <= res_letter_next;
    res_last   <= res_last_next;
    res_imp    <= res_imp_next;
    res_empty  <= res_empty_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!m_tvalid || m_tready)) begin
      out_letter                <= res_letter;
      m_tlast                   <= res_last;
      m_tuser[USER_IMPOSSIBLE]  <= res_imp;
      m_tuser[USER_EMPTY]       <= res_empty;
    end
  end

  assign m_tdata = {(DATA_W-LETTER_W)'(0), out_letter};

  // Checks
  a_held_needs_feas: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> feas)
    else $error("held letter without an active readout");

  a_held_needs_total: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> total != '0)
    else $error("held letter with zero remaining total");

  a_chain_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    ch_vld[ALPHABET_SIZE] |-> state == ST_SCAN)
    else $error("scan record arrived outside a scan");

  a_impossible_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_IMPOSSIBLE] |-> m_tlast)
    else $error("impossible result without last");

endmodule

// ===== design/nar_cell.sv =====
// ----------------------------------------------------------------------------
// nar_cell
// One letter counter of the chain. Holds its letter's count and merges it
// into the top-two record that passes through, one cell per cycle.
// ----------------------------------------------------------------------------
module nar_cell #(
  parameter int IW  = 5,
  parameter int CW  = 11,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  nar_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]      inc_idx,
  input  logic [IW-1:0]      dec_a_idx,
  input  logic [IW-1:0]      dec_b_idx,
  input  logic               in_vld,
  input  logic [CW-1:0]      in_c1,
  input  logic [IW-1:0]      in_i1,
  input  logic [CW-1:0]      in_c2,
  input  logic [IW-1:0]      in_i2,
  output logic               out_vld,
  output logic [CW-1:0]      out_c1,
  output logic [IW-1:0]      out_i1,
  output logic [CW-1:0]      out_c2,
  output logic [IW-1:0]      out_i2
);
  import nar_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Count update from the broadcast command
  always_comb begin
    count_next = count;
    if (cmd.clr) begin
      count_next = '0;
    end else if (cmd.inc && inc_idx == MY_IDX) begin
      count_next = count + CW'(1);
    end else if ((cmd.dec_a && dec_a_idx == MY_IDX) ||
                 (cmd.dec_b && dec_b_idx == MY_IDX)) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Top-two merge; strict compares keep the lower letter on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (count > in_c1) begin
      out_c1 <= count;
      out_i1 <= MY_IDX;
      out_c2 <= in_c1;
      out_i2 <= in_i1;
    end else if (count > in_c2) begin
      out_c1 <= in_c1;
      out_i1 <= in_i1;
      out_c2 <= count;
      out_i2 <= MY_IDX;
    end else begin
      out_c1 <= in_c1;
      out_i1 <= in_i1;
      out_c2 <= in_c2;
      out_i2 <= in_i2;
    end
  end

endmodule

// ===== bench/no_adjacent_repeat_reorderer_test.sv =====
// ----------------------------------------------------------------------------
// no_adjacent_repeat_reorderer_test
// Self-checking bench for the no-adjacent-repeat letter reorderer.
// ----------------------------------------------------------------------------
// Load words are written into a letter histogram. Pull words then read back
// a rearrangement with no two equal letters side by side. The bench keeps
// its own histogram and predicts every result word when the input word is
// accepted. A checker compares each output word, in order, with the oldest
// prediction. Directed cases come first: empty pulls, ignored letters, ties,
// impossible sets, loads during readout and a full store. A long output
// stall follows, then random load/pull sequences with random gaps on both
// sides.
// ----------------------------------------------------------------------------
module no_adjacent_repeat_reorderer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nar_pkg::*;

  localparam int ALPHA        = 26;
  localparam int MAX_LEN      = 1024;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 500000;

  // One predicted output word
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                impossible;
    logic                empty;
  } letter_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic [USER_W-1:0] m_tuser;

  // Predicted histogram and readout state
  logic [10:0]         letter_hist [ALPHA];
  logic [10:0]         letters_left;
  logic [LETTER_W-1:0] held_letter;
  logic                held_ok;
  logic                in_readout;

  letter_result_t due_results [$];

  // Run control and statistics
  logic idle_on   = 1'b1;
  logic long_hold = 1'b0;
  int   mismatch_count  = 0;
  int   effective_words = 0;
  int   loads_taken     = 0;
  int   pulls_taken     = 0;
  int   letters_seen    = 0;
  int   impossible_seen = 0;
  int   empty_seen      = 0;
  int   cycle_count     = 0;

  no_adjacent_repeat_reorderer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               due_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Largest nonzero count other than skip; ties go to the lower letter
  function automatic int largest_letter(input int skip);
    int best;
    int best_cnt;
    best     = ALPHA;
    best_cnt = 0;
    for (int i = 0; i < ALPHA; i++) begin
      if (i != skip && int'(letter_hist[i]) > best_cnt) begin
        best_cnt = int'(letter_hist[i]);
        best     = i;
      end
    end
    return best;
  endfunction

  function automatic void clear_hist();
    foreach (letter_hist[i]) letter_hist[i] = '0;
    letters_left = '0;
    held_letter  = '0;
    held_ok      = 1'b0;
    in_readout   = 1'b0;
  endfunction

  // Append one predicted word to the tail of the queue
  function automatic void post_result(input letter_result_t r);
    due_results = {due_results, r};
  endfunction

  // Advance the predicted state by one accepted word; returns 1 unless ignored
  function automatic bit advance_histogram(input logic op, input logic [LETTER_W-1:0] ltr);
    letter_result_t r;
    int top;
    int first;
    int second;
    r = '0;
    if (op == OP_LOAD) begin
      if (in_readout || ltr >= ALPHA || letters_left >= MAX_LEN) return 1'b0;
      letter_hist[ltr] = letter_hist[ltr] + 1'b1;
      letters_left     = letters_left + 1'b1;
      loads_taken++;
      return 1'b1;
    end
    pulls_taken++;
    if (letters_left == 0) begin
      r.empty = 1'b1;
      empty_seen++;
      post_result(r);
      return 1'b1;
    end
    // first pull of a readout checks the largest count
    if (!in_readout) begin
      top = largest_letter(ALPHA);
      if (top < ALPHA && int'(letter_hist[top]) > (int'(letters_left) + 1) / 2) begin
        clear_hist();
        r.last       = 1'b1;
        r.impossible = 1'b1;
        impossible_seen++;
        post_result(r);
        return 1'b1;
      end
      in_readout = 1'b1;
    end
    if (held_ok) begin
      r.letter    = held_letter;
      held_ok     = 1'b0;
      held_letter = '0;
    end else begin
      first = largest_letter(ALPHA);
      if (first >= ALPHA) begin
        clear_hist();
        r.empty = 1'b1;
        post_result(r);
        return 1'b1;
      end
      letter_hist[first] = letter_hist[first] - 1'b1;
      second = largest_letter(first);
      if (second < ALPHA) begin
        letter_hist[second] = letter_hist[second] - 1'b1;
        held_letter         = LETTER_W'(second);
        held_ok             = 1'b1;
      end
      r.letter = LETTER_W'(first);
    end
    letters_left = letters_left - 1'b1;
    letters_seen++;
    if (letters_left == 0 && !held_ok) begin
      r.last     = 1'b1;
      in_readout = 1'b0;
    end
    post_result(r);
    return 1'b1;
  endfunction

  // Offer one word; valid stays high afterwards so words can go back to back
  task automatic send_word(input logic op, input logic [LETTER_W-1:0] ltr);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= DATA_W'(ltr);
    do @(posedge clk); while (!s_tready);
    if (advance_histogram(op, ltr)) effective_words++;
  endtask

  task automatic load_letter(input int ltr);
    send_word(OP_LOAD, LETTER_W'(ltr));
  endtask

  task automatic pull_letter();
    send_word(OP_PULL, '0);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic flag_mismatch(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s at cycle %0d: expected %h, got %h",
               field, cycle_count, want, got);
  endtask

  // Output side: random stall bursts plus a long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long hold, counted here once armed
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    letter_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected word", '0, m_tdata);
      end else begin
        want = due_results.pop_front();
        if (m_tdata !== DATA_W'(want.letter))
          flag_mismatch("out_letter", DATA_W'(want.letter), m_tdata);
        if (m_tlast !== want.last)
          flag_mismatch("last", DATA_W'(want.last), DATA_W'(m_tlast));
        if (m_tuser[USER_IMPOSSIBLE] !== want.impossible)
          flag_mismatch("impossible", DATA_W'(want.impossible),
                        DATA_W'(m_tuser[USER_IMPOSSIBLE]));
        if (m_tuser[USER_EMPTY] !== want.empty)
          flag_mismatch("empty_res", DATA_W'(want.empty), DATA_W'(m_tuser[USER_EMPTY]));
      end
    end
  end

  // Empty pulls, ignored letters, ties, impossible sets, loads during readout
  task automatic test_directed_cases();
    pull_letter();
    load_letter(26);
    load_letter(31);
    pull_letter();
    load_letter(0);
    pull_letter();
    load_letter(0);
    load_letter(0);
    load_letter(25);
    repeat (3) pull_letter();
    // tie between two letters: lower one first
    load_letter(5);
    load_letter(2);
    load_letter(5);
    load_letter(2);
    repeat (4) pull_letter();
    // three of one letter in four: no arrangement, store cleared
    load_letter(3);
    load_letter(3);
    load_letter(3);
    load_letter(4);
    pull_letter();
    pull_letter();
    // load while a readout is under way is dropped
    load_letter(16);
    load_letter(8);
    pull_letter();
    load_letter(1);
    pull_letter();
    pull_letter();
  endtask

  // Fill to capacity; the extra load must be dropped, leaving it infeasible
  task automatic test_store_full();
    repeat (513) load_letter(0);
    repeat (511) load_letter(1);
    load_letter(1);
    pull_letter();
    pull_letter();
  endtask

  // Output held off for a long stretch while input keeps coming
  task automatic test_output_stall();
    wait_drained();
    long_hold = 1'b1;
    // two of each of four letters: always arrangeable, so the readout stalls
    for (int i = 0; i < 8; i++) load_letter(i % 4);
    do pull_letter(); while (in_readout);
    wait_drained();
  endtask

  // Mostly well-formed load/pull sequences, some noise and cut-short readouts
  task automatic test_random_sequences();
    int start;
    int done;
    int count;
    int pool;
    int base;
    int ltr;
    int cut;
    int pulled;
    bit dominant;
    start = effective_words;
    done  = 0;
    while (done < RANDOM_ITEMS) begin
      idle_on = (done < RANDOM_ITEMS - 150) && ((done / 120) % 4 != 3);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          send_word(logic'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, 31)));
      end else begin
        count    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 12);
        pool     = ($urandom_range(0, 5) == 0) ? ALPHA : $urandom_range(1, 4);
        base     = $urandom_range(0, ALPHA - pool);
        dominant = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
          ltr = (dominant && $urandom_range(0, 1) == 0) ? base
                                                        : base + $urandom_range(0, pool - 1);
          load_letter(ltr);
        end
        cut    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
        pulled = 0;
        do begin
          pull_letter();
          pulled++;
          if (in_readout && $urandom_range(0, 7) == 0) load_letter($urandom_range(0, 31));
        end while (in_readout && (cut == 0 || pulled < cut));
      end
      done = effective_words - start;
    end
  endtask

  // Test sequence
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_LOAD;
    clear_hist();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_store_full();
    test_output_stall();
    test_random_sequences();

    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads and %0d pulls: %0d letters out, %0d impossible, %0d empty",
             loads_taken, pulls_taken, letters_seen, impossible_seen, empty_seen);
    $display("store filled to capacity once, long output stall once, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== no_adjacent_repeat_reorderer.f =====
design/nar_pkg.sv
design/nar_cell.sv
design/no_adjacent_repeat_reorderer.sv
bench/no_adjacent_repeat_reorderer_test.sv
